[rtl/core/itp_pkg.sv]
package itp_pkg;

	// operator stack size
	localparam int STACK_DEPTH = 32;
	localparam int CNTW = $clog2(STACK_DEPTH + 1);
	localparam int IDXW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH - 1) : 1;

	// recognized characters
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	// error codes on the result
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNMATCHED = 2'd2;

	// source of the result character
	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_TOP,
		SEL_ITEM
	} sym_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       push;
		logic       pop;
		logic       emit;
		sym_sel_t   sel;
		logic       last;
		logic       done;
		logic [1:0] err;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [7:0] item_sym;
		logic       item_end;
		logic [7:0] top;
		logic [7:0] below;
		logic       empty;
		logic       one;
		logic       full;
		logic       out_free;
	} dp_stat_t;

	// precedence: 3 for caret, 2 for mul/div, 1 for add/sub, 0 otherwise
	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		p = 2'd0;
		if (c == CH_CARET)
			p = 2'd3;
		else if (c == CH_STAR || c == CH_SLASH)
			p = 2'd2;
		else if (c == CH_PLUS || c == CH_MINUS)
			p = 2'd1;
		return p;
	endfunction

endpackage

[rtl/core/itp_dp.sv]
module itp_dp import itp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] symbol,
	input  logic       end_of_expr,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	output logic [7:0] out_symbol,
	output logic       has_symbol,
	output logic       run_last,
	output logic       expr_done,
	output logic [1:0] error_code,
	output logic       out_valid,
	input  logic       out_stall
);

	// held input item
	logic [7:0] item_sym_q;
	logic       item_end_q;

	// stack: top in its own register, the rest below it in an array
	logic [7:0]      top_q;
	logic [7:0]      stk_q [STACK_DEPTH-1];
	logic [CNTW-1:0] cnt_q;
	logic [CNTW-1:0] cnt_m1;
	logic [CNTW-1:0] cnt_m2;
	logic [7:0]      below;

	// result register
	logic       out_valid_q;
	logic [7:0] out_symbol_q;
	logic       has_symbol_q;
	logic       run_last_q;
	logic       expr_done_q;
	logic [1:0] error_code_q;

	assign cnt_m1 = cnt_q - CNTW'(1);
	assign cnt_m2 = cnt_q - CNTW'(2);
	assign below  = (cnt_q >= CNTW'(2)) ? stk_q[cnt_m2[IDXW-1:0]] : 8'd0;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_sym_q <= symbol;
			item_end_q <= end_of_expr;
		end
	end

	// spill old top into the array on a plain push
	always_ff @(posedge clk) begin
		if (cmd.push && !cmd.pop && cnt_q != '0)
			stk_q[cnt_m1[IDXW-1:0]] <= top_q;
	end

	// top register; pop and push together replace the top
	always_ff @(posedge clk) begin
		if (cmd.push)
			top_q <= item_sym_q;
		else if (cmd.pop)
			top_q <= below;
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.push && !cmd.pop) begin
			cnt_q <= cnt_q + CNTW'(1);
		end else if (cmd.pop && !cmd.push) begin
			cnt_q <= cnt_m1;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.sel)
				SEL_TOP: begin
					out_symbol_q <= top_q;
					has_symbol_q <= 1'b1;
				end
				SEL_ITEM: begin
					out_symbol_q <= item_sym_q;
					has_symbol_q <= 1'b1;
				end
				default: begin
					out_symbol_q <= 8'd0;
					has_symbol_q <= 1'b0;
				end
			endcase
			run_last_q   <= cmd.last;
			expr_done_q  <= cmd.done;
			error_code_q <= cmd.err;
		end
	end

	// status back to the controller
	always_comb begin
		stat.item_sym = item_sym_q;
		stat.item_end = item_end_q;
		stat.top      = top_q;
		stat.below    = below;
		stat.empty    = (cnt_q == '0);
		stat.one      = (cnt_q == CNTW'(1));
		stat.full     = (cnt_q == CNTW'(STACK_DEPTH));
		stat.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_symbol_q;
	assign has_symbol = has_symbol_q;
	assign run_last   = run_last_q;
	assign expr_done  = expr_done_q;
	assign error_code = error_code_q;

endmodule

[rtl/core/itp_ctrl.sv]
module itp_ctrl import itp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t     state_q;
	dp_cmd_t    act;
	logic       act_end;
	logic       go;
	logic [1:0] p_item;
	logic [1:0] p_top;
	logic [1:0] p_below;

	assign p_item  = prec_of(stat.item_sym);
	assign p_top   = prec_of(stat.top);
	assign p_below = prec_of(stat.below);

	// one stack step for the held item
	always_comb begin
		act     = '0;
		act.sel = SEL_NONE;
		act.err = ERR_NONE;
		act_end = 1'b0;
		if (stat.item_end) begin
			// flush from the top, then the done beat
			act.emit = 1'b1;
			if (!stat.empty) begin
				act.pop = 1'b1;
				act.sel = SEL_TOP;
			end else begin
				act.done = 1'b1;
				act.last = 1'b1;
				act_end  = 1'b1;
			end
		end else if (p_item != 2'd0 || stat.item_sym == CH_LPAR) begin
			if (p_item != 2'd0 && !stat.empty && p_top >= p_item) begin
				// pop; on the final pop push in the same cycle
				act.pop  = 1'b1;
				act.emit = 1'b1;
				act.sel  = SEL_TOP;
				act.last = stat.one || (p_below < p_item);
				act.push = act.last;
				act_end  = act.last;
			end else if (stat.full) begin
				act.emit = 1'b1;
				act.last = 1'b1;
				act.err  = ERR_OVERFLOW;
				act_end  = 1'b1;
			end else begin
				act.push = 1'b1;
				act_end  = 1'b1;
			end
		end else if (stat.item_sym == CH_RPAR) begin
			if (stat.empty) begin
				act.emit = 1'b1;
				act.last = 1'b1;
				act.err  = ERR_UNMATCHED;
				act_end  = 1'b1;
			end else if (stat.top == CH_LPAR) begin
				// drop the matching open parenthesis
				act.pop = 1'b1;
				act_end = 1'b1;
			end else begin
				act.pop  = 1'b1;
				act.emit = 1'b1;
				act.sel  = SEL_TOP;
				act.last = !stat.one && (stat.below == CH_LPAR);
			end
		end else begin
			// operand passes through
			act.emit = 1'b1;
			act.sel  = SEL_ITEM;
			act.last = 1'b1;
			act_end  = 1'b1;
		end
	end

	// a step that emits waits for the result register
	assign go = (state_q == S_RUN) && (stat.out_free || !act.emit);

	always_comb begin
		cmd      = '0;
		cmd.sel  = SEL_NONE;
		cmd.err  = ERR_NONE;
		if (go)
			cmd = act;
		cmd.load = (state_q == S_IDLE) && in_valid;
	end

	assign in_stall = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_RUN;
				end
				S_RUN: begin
					if (go && act_end)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/infix_to_postfix_converter_core.sv]
// channel  beat fields                                              handshake
// -------  -------------------------------------------------------  --------------------
// in       symbol[7:0], end_of_expr                                 in_valid / in_stall
// out      out_symbol[7:0], has_symbol, run_last, expr_done,        out_valid / out_stall
//          error_code[1:0]
//
// an item takes a capture step, then stack steps: an operand, a plain push or an overflow
// is a single step; an operator pops each entry in its own step, its push sharing the step
// of the last pop; a close paren pops each operator, then the open paren; a flush pops each
// entry, then sends the done beat. the controller does one stack step per unstalled cycle.
// reset clears the fill count, sequencer and result valid; stack contents are not cleared.
// a step that emits a beat waits while the result register is full and stalled.
module infix_to_postfix_converter_core import itp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       end_of_expr,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_symbol,
	output logic       has_symbol,
	output logic       run_last,
	output logic       expr_done,
	output logic [1:0] error_code
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stack and result register
	itp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.symbol      (symbol),
		.end_of_expr (end_of_expr),
		.cmd         (cmd),
		.stat        (stat),
		.out_symbol  (out_symbol),
		.has_symbol  (has_symbol),
		.run_last    (run_last),
		.expr_done   (expr_done),
		.error_code  (error_code),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

	// an accepted beat starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted beat did not start work");

	// never pop an empty stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.empty)
		else $error("pop of empty stack");

	// done beat closes the item and carries no character
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && expr_done) |-> (run_last && !has_symbol))
		else $error("done beat malformed");

	// error beat closes the item and carries no character
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code != ERR_NONE) |-> (run_last && !has_symbol))
		else $error("error beat malformed");

endmodule
